/* rtl/flhd_pkg.sv */
// shared types, constants and slope helper for the facility location hull dp core
package flhd_pkg;

    localparam int MAX_SITES_DFLT = 65536;
    localparam int POS_W  = 20;
    localparam int AMT_W  = 16;
    localparam int BC_W   = 32;
    localparam int COST_W = 53;
    localparam int SUM_W  = 32;
    localparam int WSUM_W = 52;
    localparam int HGT_W  = 54;
    localparam int HALF_W = 27;
    localparam int ACC_W  = HGT_W + SUM_W;
    localparam int PRD_W  = ACC_W + 1;
    localparam int PNT_W  = SUM_W + HGT_W;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [SUM_W-1:0]  ASUM_MAX = {SUM_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CMP,
        ST_COST,
        ST_TAIL_RD,
        ST_TAIL_SLP,
        ST_MUL_A0,
        ST_MUL_A1,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_TAIL_DEC,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic head_rd;
        logic head_pop;
        logic cost;
        logic tail_rd;
        logic tail_slope;
        logic mul_en;
        logic mul_b;
        logic mul_hi;
        logic tail_pop;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic lt;
        logic head_pop_ok;
        logic inf1;
        logic inf2;
        logic tail_pop_ok;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic              inf;
        logic              neg;
        logic [HGT_W-1:0]  mag;
        logic [SUM_W-1:0]  dx;
    } t_slope;

    function automatic t_slope make_slope(input logic [SUM_W-1:0] sa,
                                          input logic [HGT_W-1:0] ya,
                                          input logic [SUM_W-1:0] sb,
                                          input logic [HGT_W-1:0] yb);
        logic signed [SUM_W:0] ddx;
        logic signed [HGT_W:0] dy;
        t_slope                r;
        ddx = $signed({1'b0, sb}) - $signed({1'b0, sa});
        if (ddx < 0) begin
            dy   = $signed({1'b0, ya}) - $signed({1'b0, yb});
            r.dx = SUM_W'(-ddx);
        end else begin
            dy   = $signed({1'b0, yb}) - $signed({1'b0, ya});
            r.dx = SUM_W'(ddx);
        end
        r.inf = (ddx == 0);
        r.neg = dy[HGT_W];
        r.mag = dy[HGT_W] ? HGT_W'(-dy) : HGT_W'(dy);
        return r;
    endfunction

endpackage

/* rtl/flhd_ram.sv */
// generic simple dual port ram with registered read
module flhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/flhd_ctrl.sv */
// sequencer for head pops, cost, tail pops and push
module flhd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  flhd_pkg::t_sts i_sts,
    output flhd_pkg::t_cmd o_cmd
);

    flhd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flhd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            flhd_pkg::ST_IDLE:     if (i_valid) n_state = flhd_pkg::ST_HEAD_RD;
            flhd_pkg::ST_HEAD_RD:  n_state = i_sts.lt ? flhd_pkg::ST_HEAD_CMP
                                                      : flhd_pkg::ST_COST;
            flhd_pkg::ST_HEAD_CMP: n_state = i_sts.head_pop_ok ? flhd_pkg::ST_HEAD_RD
                                                               : flhd_pkg::ST_COST;
            flhd_pkg::ST_COST:     n_state = flhd_pkg::ST_TAIL_RD;
            flhd_pkg::ST_TAIL_RD:  n_state = i_sts.lt ? flhd_pkg::ST_TAIL_SLP
                                                      : flhd_pkg::ST_PUSH;
            flhd_pkg::ST_TAIL_SLP: begin
                if (i_sts.inf1) n_state = flhd_pkg::ST_TAIL_RD;
                else if (i_sts.inf2) n_state = flhd_pkg::ST_PUSH;
                else n_state = flhd_pkg::ST_MUL_A0;
            end
            flhd_pkg::ST_MUL_A0:   n_state = flhd_pkg::ST_MUL_A1;
            flhd_pkg::ST_MUL_A1:   n_state = flhd_pkg::ST_MUL_B0;
            flhd_pkg::ST_MUL_B0:   n_state = flhd_pkg::ST_MUL_B1;
            flhd_pkg::ST_MUL_B1:   n_state = flhd_pkg::ST_TAIL_DEC;
            flhd_pkg::ST_TAIL_DEC: n_state = i_sts.tail_pop_ok ? flhd_pkg::ST_TAIL_RD
                                                               : flhd_pkg::ST_PUSH;
            flhd_pkg::ST_PUSH:     if (i_sts.out_free) n_state = flhd_pkg::ST_IDLE;
            default:               n_state = flhd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            flhd_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            flhd_pkg::ST_HEAD_RD:  o_cmd.head_rd  = i_sts.lt;
            flhd_pkg::ST_HEAD_CMP: o_cmd.head_pop = i_sts.head_pop_ok;
            flhd_pkg::ST_COST:     o_cmd.cost     = 1'b1;
            flhd_pkg::ST_TAIL_RD:  o_cmd.tail_rd  = i_sts.lt;
            flhd_pkg::ST_TAIL_SLP: begin
                o_cmd.tail_slope = 1'b1;
                o_cmd.tail_pop   = i_sts.inf1;
            end
            flhd_pkg::ST_MUL_A0: o_cmd.mul_en = 1'b1;
            flhd_pkg::ST_MUL_A1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
            end
            flhd_pkg::ST_MUL_B0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_b  = 1'b1;
            end
            flhd_pkg::ST_MUL_B1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_b  = 1'b1;
                o_cmd.mul_hi = 1'b1;
            end
            flhd_pkg::ST_TAIL_DEC: o_cmd.tail_pop = i_sts.tail_pop_ok;
            flhd_pkg::ST_PUSH:     o_cmd.push     = i_sts.out_free;
            default:               o_cmd = '0;
        endcase
    end

endmodule

/* rtl/flhd_dp.sv */
// datapath: running sums, deque pointers, hull ram, slope compare and output word
module flhd_dp #(
    parameter int MAX_SITES = flhd_pkg::MAX_SITES_DFLT,
    localparam int PTR_W = $clog2(MAX_SITES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  flhd_pkg::t_cmd                i_cmd,
    output flhd_pkg::t_sts                o_sts,
    input  logic [flhd_pkg::POS_W-1:0]    i_site_position,
    input  logic [flhd_pkg::AMT_W-1:0]    i_goods_amount,
    input  logic [flhd_pkg::BC_W-1:0]     i_build_cost,
    input  logic                          i_last_site,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [flhd_pkg::COST_W-1:0]   o_site_cost,
    output logic [flhd_pkg::COST_W-1:0]   o_best_total,
    output logic                          o_run_done
);

    localparam int SW = flhd_pkg::SUM_W;
    localparam int HW = flhd_pkg::HGT_W;
    localparam int CW = flhd_pkg::COST_W;
    localparam int WW = flhd_pkg::WSUM_W;
    localparam int QW = flhd_pkg::HALF_W;
    localparam int AW = flhd_pkg::ACC_W;
    localparam int PW = flhd_pkg::PRD_W;

    logic [flhd_pkg::POS_W-1:0] r_x;
    logic [flhd_pkg::AMT_W-1:0] r_p;
    logic [flhd_pkg::BC_W-1:0]  r_c;
    logic                       r_last;
    logic [SW-1:0]              r_asum;
    logic [WW-1:0]              r_wsum;
    logic [PTR_W-1:0]           r_head, r_tail;
    logic [SW-1:0]              r_hsum, r_tsum;
    logic [HW-1:0]              r_hhgt, r_thgt;
    logic [CW-1:0]              r_cost;
    logic [HW-1:0]              r_y;
    flhd_pkg::t_slope           r_s1, r_s2;
    logic [AW-1:0]              r_acc;
    logic signed [PW-1:0]       r_pa, r_pb;
    logic [CW-1:0]              r_best;
    logic                       r_seen;
    logic                       r_oval;
    logic [CW-1:0]              r_ocost, r_obest;
    logic                       r_odone;
    logic                       r_rdzero;

    // hull ram
    logic [PTR_W-1:0]            raddr, waddr;
    logic                        re, we;
    logic [flhd_pkg::PNT_W-1:0]  rdata;
    logic [SW-1:0]               rd_sum;
    logic [HW-1:0]               rd_hgt;
    logic                        full;

    assign full  = (r_tail == PTR_W'(MAX_SITES));
    assign re    = i_cmd.head_rd | i_cmd.tail_rd;
    assign raddr = i_cmd.head_rd ? r_head + PTR_W'(1) : r_tail - PTR_W'(1);
    assign we    = i_cmd.push & ~full;
    assign waddr = r_tail + PTR_W'(1);

    flhd_ram #(
        .WIDTH (flhd_pkg::PNT_W),
        .DEPTH (MAX_SITES + 1)
    ) u_hull (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_asum, r_y}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // slot zero is the origin
    assign rd_sum = r_rdzero ? '0 : rdata[flhd_pkg::PNT_W-1:HW];
    assign rd_hgt = r_rdzero ? '0 : rdata[HW-1:0];

    // load sums
    logic [SW:0]   asum_add;
    logic [WW:0]   wsum_add;
    assign asum_add = {1'b0, r_asum} + (SW+1)'(i_goods_amount);
    assign wsum_add = {1'b0, r_wsum} + (WW+1)'(i_site_position * i_goods_amount);

    // head compare
    flhd_pkg::t_slope         hs;
    logic [flhd_pkg::POS_W+SW-1:0] xdx;
    assign hs  = flhd_pkg::make_slope(r_hsum, r_hhgt, rd_sum, rd_hgt);
    assign xdx = r_x * hs.dx;

    // cost
    logic signed [SW:0]   diff;
    logic signed [HW-1:0] hprod;
    logic signed [CW+3:0] total;
    logic [CW-1:0]        cost_c;
    assign diff  = $signed({1'b0, r_asum}) - $signed({1'b0, r_hsum});
    assign hprod = diff * $signed({1'b0, r_x});
    assign total = $signed({3'b0, r_hhgt}) + (CW+4)'(hprod)
                 - $signed({5'b0, r_wsum}) + $signed({25'b0, r_c});
    always_comb begin
        if (total < 0) cost_c = '0;
        else if (total > $signed({4'b0, flhd_pkg::COST_MAX})) cost_c = flhd_pkg::COST_MAX;
        else cost_c = CW'(total);
    end

    // tail slopes
    flhd_pkg::t_slope s1, s2;
    assign s1 = flhd_pkg::make_slope(rd_sum, rd_hgt, r_tsum, r_thgt);
    assign s2 = flhd_pkg::make_slope(r_tsum, r_thgt, r_asum, r_y);

    // shared multiplier, two halves per product
    logic [HW-1:0]   mpart;
    logic [SW-1:0]   mdx;
    logic [QW-1:0]   mhalf;
    logic [QW+SW-1:0] pp;
    logic [AW-1:0]   acc_n;
    logic            mneg;
    logic signed [PW-1:0] prod_s;
    assign mpart  = i_cmd.mul_b ? r_s2.mag : r_s1.mag;
    assign mdx    = i_cmd.mul_b ? r_s1.dx  : r_s2.dx;
    assign mneg   = i_cmd.mul_b ? r_s2.neg : r_s1.neg;
    assign mhalf  = i_cmd.mul_hi ? mpart[HW-1:QW] : mpart[QW-1:0];
    assign pp     = mhalf * mdx;
    assign acc_n  = i_cmd.mul_hi ? r_acc + (AW'(pp) << QW) : AW'(pp);
    assign prod_s = mneg ? -$signed({1'b0, acc_n}) : $signed({1'b0, acc_n});

    // output word
    logic out_free;
    logic new_seen;
    logic [CW-1:0] new_best;
    assign out_free = ~r_oval | ~i_out_stall;
    always_comb begin
        new_seen = r_seen;
        new_best = r_best;
        if (r_p != '0) begin
            new_seen = 1'b1;
            new_best = r_cost;
        end else if (r_seen && r_cost < r_best) begin
            new_best = r_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_asum <= '0;
            r_wsum <= '0;
            r_hsum <= '0;
            r_hhgt <= '0;
            r_tsum <= '0;
            r_thgt <= '0;
            r_best <= '0;
            r_seen <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (r_oval && !i_out_stall) r_oval <= 1'b0;
            if (i_cmd.load) begin
                r_asum <= asum_add[SW] ? flhd_pkg::ASUM_MAX : asum_add[SW-1:0];
                r_wsum <= wsum_add[WW] ? flhd_pkg::WSUM_MAX : wsum_add[WW-1:0];
            end
            if (i_cmd.head_pop) begin
                r_head <= r_head + PTR_W'(1);
                r_hsum <= rd_sum;
                r_hhgt <= rd_hgt;
            end
            if (i_cmd.tail_pop) begin
                r_tail <= r_tail - PTR_W'(1);
                r_tsum <= rd_sum;
                r_thgt <= rd_hgt;
            end
            if (i_cmd.push) begin
                r_oval <= 1'b1;
                if (r_last) begin
                    r_head <= '0;
                    r_tail <= '0;
                    r_asum <= '0;
                    r_wsum <= '0;
                    r_hsum <= '0;
                    r_hhgt <= '0;
                    r_tsum <= '0;
                    r_thgt <= '0;
                    r_best <= '0;
                    r_seen <= 1'b0;
                end else begin
                    r_best <= new_best;
                    r_seen <= new_seen;
                    if (!full) begin
                        r_tail <= r_tail + PTR_W'(1);
                        r_tsum <= r_asum;
                        r_thgt <= r_y;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_site_position;
            r_p    <= i_goods_amount;
            r_c    <= i_build_cost;
            r_last <= i_last_site;
        end
        if (re) r_rdzero <= (raddr == '0);
        if (i_cmd.cost) begin
            r_cost <= cost_c;
            r_y    <= {1'b0, cost_c} + HW'(r_wsum);
        end
        if (i_cmd.tail_slope) begin
            r_s1 <= s1;
            r_s2 <= s2;
        end
        if (i_cmd.mul_en) begin
            r_acc <= acc_n;
            if (i_cmd.mul_hi) begin
                if (i_cmd.mul_b) r_pb <= prod_s;
                else r_pa <= prod_s;
            end
        end
        if (i_cmd.push) begin
            r_ocost <= r_cost;
            r_obest <= new_seen ? new_best : '0;
            r_odone <= r_last;
        end
    end

    assign o_sts.lt          = (r_head < r_tail);
    assign o_sts.head_pop_ok = ~hs.inf & (hs.neg | (hs.mag <= HW'(xdx)));
    assign o_sts.inf1        = s1.inf;
    assign o_sts.inf2        = s2.inf;
    assign o_sts.tail_pop_ok = (r_pa >= r_pb);
    assign o_sts.out_free    = out_free;

    assign o_out_valid  = r_oval;
    assign o_site_cost  = r_ocost;
    assign o_best_total = r_obest;
    assign o_run_done   = r_odone;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("head past tail");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= PTR_W'(MAX_SITES)) else $error("tail past capacity");
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && r_last |=> r_head == '0 && r_tail == '0 && r_asum == '0)
        else $error("state not cleared at end of run");
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free) else $error("push over pending word");

endmodule

/* rtl/facility_location_hull_dp_core.sv */
// top level of the facility location hull dp core
// A site word is taken only in the idle state. The head scan reads one hull point per check and
// pops while the slope compare allows, and then the cost is formed. The tail scan reads one point
// per check: an infinite slope settles it, or else the two 86-bit cross products are formed
// (one 27x32 multiplier, two passes per product) and compared. Then the new point is pushed.
// Hull points live in one ram of MAX_SITES+1 entries with one read per check.
// A new word is taken while the previous result still waits at the output, and the push
// cycle holds until that result has left.
module facility_location_hull_dp_core #(
    parameter int MAX_SITES = flhd_pkg::MAX_SITES_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [flhd_pkg::POS_W-1:0]    i_site_position,
    input  logic [flhd_pkg::AMT_W-1:0]    i_goods_amount,
    input  logic [flhd_pkg::BC_W-1:0]     i_build_cost,
    input  logic                          i_last_site,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [flhd_pkg::COST_W-1:0]   o_site_cost,
    output logic [flhd_pkg::COST_W-1:0]   o_best_total,
    output logic                          o_run_done
);

    flhd_pkg::t_cmd cmd;
    flhd_pkg::t_sts sts;

    flhd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    flhd_dp #(
        .MAX_SITES (MAX_SITES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_site_position (i_site_position),
        .i_goods_amount  (i_goods_amount),
        .i_build_cost    (i_build_cost),
        .i_last_site     (i_last_site),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_site_cost     (o_site_cost),
        .o_best_total    (o_best_total),
        .o_run_done      (o_run_done)
    );

endmodule

/* dv/facility_location_hull_dp_core_tb.sv */
// self-checking testbench for the facility location hull dp core with a built-in cost predictor
`timescale 1ns / 100ps

module facility_location_hull_dp_core_tb;

    localparam int  SLOT_CNT   = flhd_pkg::MAX_SITES_DFLT + 1;
    localparam int  LIMIT      = 3000000;
    localparam int  CALM_TAIL  = 150;
    localparam int  RAND_ITEMS = 1150;
    localparam longint COST_TOP = (64'd1 << flhd_pkg::COST_W) - 1;
    localparam longint WSUM_TOP = (64'd1 << flhd_pkg::WSUM_W) - 1;
    localparam longint ASUM_TOP = 64'hFFFF_FFFF;

    typedef struct {
        logic [flhd_pkg::POS_W-1:0] pos;
        logic [flhd_pkg::AMT_W-1:0] amt;
        logic [flhd_pkg::BC_W-1:0]  bc;
        logic                       last;
    } t_site;

    typedef struct {
        logic [flhd_pkg::COST_W-1:0] site_cost;
        logic [flhd_pkg::COST_W-1:0] best_total;
        logic                        run_done;
    } t_costs;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [flhd_pkg::POS_W-1:0] i_site_position = '0;
    logic [flhd_pkg::AMT_W-1:0] i_goods_amount = '0;
    logic [flhd_pkg::BC_W-1:0]  i_build_cost = '0;
    logic                       i_last_site = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [flhd_pkg::COST_W-1:0] o_site_cost;
    logic [flhd_pkg::COST_W-1:0] o_best_total;
    logic                        o_run_done;

    facility_location_hull_dp_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_site_position(i_site_position), .i_goods_amount(i_goods_amount),
        .i_build_cost(i_build_cost), .i_last_site(i_last_site),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_site_cost(o_site_cost), .o_best_total(o_best_total), .o_run_done(o_run_done)
    );

    t_site  site_q[$];
    t_costs cost_q[$];
    int     n_items, n_sent, n_sent_acc, n_checked, n_errors, n_runs, n_cycles;
    int     pause_at, send_gap, recv_gap;
    bit     paused_done;

    // predictor state
    longint h_sum[SLOT_CNT];
    longint h_hgt[SLOT_CNT];
    longint h_cost[SLOT_CNT];
    int     hd, tl;
    longint amt_acc, wsum_acc, best_acc;
    bit     goods_seen;

    function automatic void hull_clear();
        h_sum[0] = 0; h_hgt[0] = 0; h_cost[0] = 0;
        hd = 0; tl = 0;
        amt_acc = 0; wsum_acc = 0; best_acc = 0; goods_seen = 0;
    endfunction

    function automatic bit slope_of(input longint xa, ya, xb, yb,
                                    output longint dy, output longint dx);
        longint ddx;
        ddx = xb - xa;
        dy = 0; dx = 0;
        if (ddx == 0) return 1'b1;
        if (ddx < 0) begin
            dx = -ddx; dy = ya - yb;
        end else begin
            dx = ddx; dy = yb - ya;
        end
        return 1'b0;
    endfunction

    function automatic t_costs site_cost_step(input t_site s);
        longint x, p, c, sm, wm, dy, dx, dy2, dx2, total, yy, cj, wj;
        bit inf1, inf2, pop;
        logic signed [127:0] lhs, rhs;
        t_costs r;
        x = s.pos; p = s.amt; c = s.bc;
        sm = amt_acc + p;
        wm = wsum_acc + x * p;
        if (sm > ASUM_TOP) sm = ASUM_TOP;
        if (wm > WSUM_TOP) wm = WSUM_TOP;
        while (hd < tl) begin
            if (slope_of(h_sum[hd], h_hgt[hd], h_sum[hd+1], h_hgt[hd+1], dy, dx)) break;
            if (dy > x * dx) break;
            hd++;
        end
        cj = h_cost[hd];
        wj = h_hgt[hd] - cj;
        total = cj + x * (sm - h_sum[hd]) - (wm - wj) + c;
        if (total < 0) total = 0;
        if (total > COST_TOP) total = COST_TOP;
        yy = total + wm;
        while (hd < tl) begin
            inf1 = slope_of(h_sum[tl-1], h_hgt[tl-1], h_sum[tl], h_hgt[tl], dy, dx);
            inf2 = slope_of(h_sum[tl], h_hgt[tl], sm, yy, dy2, dx2);
            if (inf1) pop = 1;
            else if (inf2) pop = 0;
            else begin
                lhs = 128'(signed'(dy)) * 128'(signed'(dx2));
                rhs = 128'(signed'(dy2)) * 128'(signed'(dx));
                pop = (lhs >= rhs);
            end
            if (!pop) break;
            tl--;
        end
        if (tl < flhd_pkg::MAX_SITES_DFLT) begin
            tl++;
            h_sum[tl] = sm; h_hgt[tl] = yy; h_cost[tl] = total;
        end
        amt_acc = sm; wsum_acc = wm;
        if (p != 0) begin
            goods_seen = 1; best_acc = total;
        end else if (goods_seen && total < best_acc) begin
            best_acc = total;
        end
        r.site_cost  = total[flhd_pkg::COST_W-1:0];
        r.best_total = goods_seen ? best_acc[flhd_pkg::COST_W-1:0] : '0;
        r.run_done   = s.last;
        if (s.last) hull_clear();
        return r;
    endfunction

    function automatic void add_site(input logic [flhd_pkg::POS_W-1:0] pos,
                                     input logic [flhd_pkg::AMT_W-1:0] amt,
                                     input logic [flhd_pkg::BC_W-1:0] bc, input logic last);
        t_site s;
        s.pos = pos; s.amt = amt; s.bc = bc; s.last = last;
        site_q.push_back(s);
        n_items++;
        if (last) n_runs++;
    endfunction

    function automatic void add_random_run();
        int len, k, step;
        longint pos;
        bit shuffled;
        logic [flhd_pkg::AMT_W-1:0] amt;
        logic [flhd_pkg::BC_W-1:0]  bc;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
        shuffled = ($urandom_range(0, 9) == 0);
        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048575) : $urandom_range(0, 1000);
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
                0: amt = '0;
                1: amt = flhd_pkg::AMT_W'($urandom_range(1, 20));
                default: amt = flhd_pkg::AMT_W'($urandom);
            endcase
            bc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100000) : $urandom;
            if (shuffled) pos = $urandom_range(0, 1048575);
            add_site(pos[flhd_pkg::POS_W-1:0], amt, bc, k == len - 1);
            if (!shuffled) begin
                step = ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200000)
                                                   : $urandom_range(1, 3000);
                pos = pos + step;
                if (pos > 1048575) pos = 1048575;
            end
        end
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("facility_location_hull_dp_core_tb NOT OK");
            $finish;
        end
    end

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cost_q.push_back(site_cost_step('{i_site_position, i_goods_amount,
                                                  i_build_cost, i_last_site}));
                n_sent_acc <= n_sent_acc + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (site_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (n_sent == pause_at && !paused_done &&
                             (n_checked != n_sent || (i_valid && !o_stall))) begin
                    i_valid <= 1'b0;
                end else if (n_sent < n_items - CALM_TAIL && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 16) - 1;
                    i_valid <= 1'b0;
                end else begin
                    t_site s;
                    s = site_q.pop_front();
                    if (n_sent == pause_at) paused_done <= 1'b1;
                    i_site_position <= s.pos;
                    i_goods_amount  <= s.amt;
                    i_build_cost    <= s.bc;
                    i_last_site     <= s.last;
                    i_valid <= 1'b1;
                    n_sent <= n_sent + 1;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (cost_q.size() == 0) begin
                    $error("result word with nothing expected");
                    n_errors++;
                end else begin
                    t_costs e;
                    e = cost_q.pop_front();
                    if (o_site_cost !== e.site_cost) begin
                        $error("site_cost expected %0d actual %0d", e.site_cost, o_site_cost);
                        n_errors++;
                    end
                    if (o_best_total !== e.best_total) begin
                        $error("best_total expected %0d actual %0d", e.best_total, o_best_total);
                        n_errors++;
                    end
                    if (o_run_done !== e.run_done) begin
                        $error("run_done expected %0d actual %0d", e.run_done, o_run_done);
                        n_errors++;
                    end
                end
                n_checked <= n_checked + 1;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (n_checked < n_items - CALM_TAIL && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 16) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int k;
        n_items = 0; n_sent = 0; n_sent_acc = 0; n_checked = 0; n_errors = 0;
        n_runs = 0; n_cycles = 0; send_gap = 0; recv_gap = 0; paused_done = 0;
        hull_clear();
        // extremes, equal sums from zero goods, top position
        add_site(0, 0, 0, 0);
        add_site(0, 16'hFFFF, 32'hFFFF_FFFF, 0);
        add_site(20'hFFFFF, 16'hFFFF, 0, 0);
        add_site(20'hFFFFF, 0, 5, 1);
        // one site run with no goods
        add_site(500, 0, 7, 1);
        // decreasing positions, cost clamps at zero
        add_site(1000, 100, 10, 0);
        add_site(10, 50, 0, 0);
        add_site(0, 16'hFFFF, 0, 1);
        // zero goods before and after goods
        add_site(5, 0, 3, 0);
        add_site(6, 0, 1, 0);
        add_site(7, 3, 9, 0);
        add_site(8, 0, 0, 0);
        add_site(9, 0, 32'hFFFF_FFFF, 1);
        // steadily growing run with mixed extremes
        for (k = 0; k < 10; k++)
            add_site(flhd_pkg::POS_W'(k * 100000), (k % 2) ? 16'hFFFF : 16'h0001,
                     (k % 3) ? 32'd0 : 32'hFFFF_FFFF, k == 9);
        while (n_items < RAND_ITEMS) add_random_run();
        pause_at = n_items / 2;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (site_q.size() == 0 && n_sent_acc == n_items);
        wait (cost_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d sites in %0d runs, %0d result words checked", n_items, n_runs,
                 n_checked);
        if (n_errors == 0 && cost_q.size() == 0 && n_checked == n_items)
            $display("facility_location_hull_dp_core_tb OK");
        else
            $display("facility_location_hull_dp_core_tb NOT OK");
        $finish;
    end

endmodule
